// ----- design/tdpt_pkg.sv -----
// Shared widths, constants and width helpers for the trial-division prime tester.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    // Width of the arithmetic datapath; the value field is zero-extended or truncated to it.
    localparam int VALUE_BITS = 32;

    // Bit counter for the restoring divider, one quotient bit per cycle.
    localparam int CNT_W = $clog2(VALUE_BITS);

    // Fixed field widths of the stream payloads.
    localparam int FIELD_W    = 32;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 40;

    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [FIELD_W-1:0]    t_field;

    // Bring the 32-bit input field to the datapath width.
    function automatic t_val to_val(input t_field x);
        logic [63:0] ext;
        ext = 64'(x);
        return ext[VALUE_BITS-1:0];
    endfunction

    // Bring a datapath value back to the 32-bit result field.
    function automatic t_field to_field(input t_val v);
        logic [63:0] ext;
        ext = 64'(v);
        return ext[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/trial_division_prime_test.sv -----
// Top level: trial-division primality test and next-prime search around one shared divider.
// A type 0 request with a value below 4 or even is settled without the divider. Otherwise the
// test runs trial divisions on the shared restoring divider: one division by 3 and then
// two divisions (6k-1, 6k+1) per step while the divisor squared stays at or below the value.
// Type 1 repeats that test for each candidate above the value; one request is taken at a time.
// Reset (synchronous, active low) returns the sequencer to idle and drops the result valid.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire [IN_TDATA_W-1:0]   i_s_axis_tdata,  // [31:0] value
    input  wire                    i_s_axis_tuser,  // [0] req_type
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // [0] is_prime_flag,
                                                    // [32:1] next_prime_value,
                                                    // [33] overflow, [39:34] zero
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NEXT  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Which divisor the current division belongs to.
    localparam logic [1:0] PH_THREE = 2'd0;
    localparam logic [1:0] PH_LO    = 2'd1;
    localparam logic [1:0] PH_HI    = 2'd2;

    localparam t_val VAL_ALL_ONES = '1;

    logic [2:0]       r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             r_type, n_type;
    t_val             r_cand, n_cand;
    t_val             r_div, n_div;
    t_val             r_rem, n_rem;
    t_val             r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_phase, n_phase;
    logic             r_res_flag, n_res_flag;
    t_field           r_res_next, n_res_next;
    logic             r_res_ovf, n_res_ovf;
    logic             r_out_flag, n_out_flag;
    t_field           r_out_next, n_out_next;
    logic             r_out_ovf, n_out_ovf;

    logic             in_acc;
    logic             out_free;
    logic [VALUE_BITS:0] div_trial;
    logic [VALUE_BITS:0] div_diff;
    logic             div_fits;
    logic             verdict_valid;
    logic             verdict_prime;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // One step of the restoring divider: shift in the next dividend bit and try a subtract.
    assign div_trial = {r_rem, r_quo[VALUE_BITS-1]};
    assign div_diff  = div_trial - {1'b0, r_div};
    assign div_fits  = !div_diff[VALUE_BITS];

    // Sequencer next-state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_type      = r_type;
        n_cand      = r_cand;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_res_flag  = r_res_flag;
        n_res_next  = r_res_next;
        n_res_ovf   = r_res_ovf;
        n_out_flag  = r_out_flag;
        n_out_next  = r_out_next;
        n_out_ovf   = r_out_ovf;
        verdict_valid = 1'b0;
        verdict_prime = 1'b0;

        // The result leaves when the downstream side takes it.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_type  = i_s_axis_tuser;
                    n_cand  = to_val(i_s_axis_tdata);
                    n_state = i_s_axis_tuser ? S_NEXT : S_CHECK;
                end
            end
            S_NEXT: begin
                // No larger candidate fits the datapath width.
                if (r_cand == VAL_ALL_ONES) begin
                    n_res_flag = 1'b0;
                    n_res_next = '0;
                    n_res_ovf  = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_cand  = r_cand + t_val'(1);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // Small values and even values are settled without dividing.
                if (r_cand < t_val'(2)) begin
                    verdict_valid = 1'b1;
                    verdict_prime = 1'b0;
                end else if (r_cand < t_val'(4)) begin
                    verdict_valid = 1'b1;
                    verdict_prime = 1'b1;
                end else if (!r_cand[0]) begin
                    verdict_valid = 1'b1;
                    verdict_prime = 1'b0;
                end else begin
                    n_div   = t_val'(3);
                    n_phase = PH_THREE;
                    n_rem   = '0;
                    n_quo   = r_cand;
                    n_cnt   = CNT_W'(VALUE_BITS - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = div_fits ? div_diff[VALUE_BITS-1:0] : div_trial[VALUE_BITS-1:0];
                n_quo = {r_quo[VALUE_BITS-2:0], div_fits};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                // Default is another division of the candidate.
                n_rem   = '0;
                n_quo   = r_cand;
                n_cnt   = CNT_W'(VALUE_BITS - 1);
                n_state = S_DIV;
                unique case (r_phase)
                    PH_THREE: begin
                        if (r_rem == '0) begin
                            verdict_valid = 1'b1;
                            verdict_prime = 1'b0;
                        end else begin
                            n_div   = t_val'(5);
                            n_phase = PH_LO;
                        end
                    end
                    PH_LO: begin
                        // The divisor has passed the square root: no factor left.
                        if (r_div > r_quo) begin
                            verdict_valid = 1'b1;
                            verdict_prime = 1'b1;
                        end else if (r_rem == '0) begin
                            verdict_valid = 1'b1;
                            verdict_prime = 1'b0;
                        end else begin
                            n_div   = r_div + t_val'(2);
                            n_phase = PH_HI;
                        end
                    end
                    PH_HI: begin
                        if (r_rem == '0) begin
                            verdict_valid = 1'b1;
                            verdict_prime = 1'b0;
                        end else begin
                            n_div   = r_div + t_val'(4);
                            n_phase = PH_LO;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_flag  = r_res_flag;
                    n_out_next  = r_res_next;
                    n_out_ovf   = r_res_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished test either answers the request or moves the search to the next candidate.
        if (verdict_valid) begin
            if (!r_type) begin
                n_res_flag = verdict_prime;
                n_res_next = '0;
                n_res_ovf  = 1'b0;
                n_state    = S_DONE;
            end else if (verdict_prime) begin
                n_res_flag = 1'b1;
                n_res_next = to_field(r_cand);
                n_res_ovf  = 1'b0;
                n_state    = S_DONE;
            end else begin
                n_state = S_NEXT;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_cand     <= n_cand;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_phase    <= n_phase;
        r_res_flag <= n_res_flag;
        r_res_next <= n_res_next;
        r_res_ovf  <= n_res_ovf;
        r_out_flag <= n_out_flag;
        r_out_next <= n_out_next;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_ovf, r_out_next, r_out_flag};

endmodule

`default_nettype wire

// ----- design/tdpt_checker.sv -----
// Port-level checker for the prime tester, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_checker
    import tdpt_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_axis_tvalid,
    input wire                   o_s_axis_tready,
    input wire [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input wire                   i_s_axis_tuser,
    input wire                   o_m_axis_tvalid,
    input wire                   i_m_axis_tready,
    input wire [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // No result is pending right after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A taken request keeps the input closed while it is worked on.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while busy");

    // Overflow carries no prime and no flag.
    a_ovf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[33]) |->
        (!o_m_axis_tdata[0] && (o_m_axis_tdata[32:1] == '0)))
        else $error("overflow result with data");

    // A reported next prime is odd or two.
    a_next_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[32:1] != '0)) |->
        (o_m_axis_tdata[1] || (o_m_axis_tdata[32:1] == 32'd2)))
        else $error("even next prime");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
